// ===== design/absp_pkg.sv =====
// ---------------------------------------------------------------------------
// absp_pkg
// Shared types and constants for the adaptive buffer size policy block.
// ---------------------------------------------------------------------------
package absp_pkg;

  localparam int NUM_BUCKETS_DEF = 16;

  localparam int BASIC_W = 21;
  localparam int SIZE_W  = 32;
  localparam int WINT_W  = 40;
  localparam int PCT_W   = 7;
  localparam int TIME_W  = 48;
  localparam int HND_W   = 8;
  localparam int CFG_W   = 40;
  localparam int CIDX_W  = 3;

  localparam logic [1:0] OP_ACQUIRE = 2'd0;
  localparam logic [1:0] OP_RECLAIM = 2'd1;
  localparam logic [1:0] OP_PURGE   = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
  localparam logic [2:0] ST_BUSY      = 3'd2;
  localparam logic [2:0] ST_WRONG_HND = 3'd3;
  localparam logic [2:0] ST_PURGE_USE = 3'd4;

  localparam logic [CIDX_W-1:0] REG_BASIC_SIZE    = 3'd0;
  localparam logic [CIDX_W-1:0] REG_BUFFER_LIMIT  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_MAX_REQUEST   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_WASH_INTERVAL = 3'd3;
  localparam logic [CIDX_W-1:0] REG_WASH_PERCENT  = 3'd4;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CHK  = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_DBL  = 7'b0001000,
    S_CNT  = 7'b0010000,
    S_SCAN = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    CMD_NONE = 3'd0,
    CMD_LOAD = 3'd1,
    CMD_DIV  = 3'd2,
    CMD_DBL  = 3'd3,
    CMD_CNT  = 3'd4,
    CMD_SCAN = 3'd5,
    CMD_FIN  = 3'd6
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       acq_stop;
    logic       rcl_stop;
    logic       div_done;
    logic       dbl_done;
    logic       cnt_done;
    logic       scan_done;
  } dp_flags_t;

endpackage

// ===== design/adaptive_buffer_size_policy.sv =====
// ---------------------------------------------------------------------------
// adaptive_buffer_size_policy
// Single-client reusable buffer manager: acquire, reclaim and purge.
// ---------------------------------------------------------------------------
// Usage:
//   Raise start with in_operation, in_request_size, in_handle and in_now; the
//   operation is taken when start is high and busy is low. busy stays high
//   while the operation runs. Exactly one result follows: out_valid is high
//   for one cycle with out_granted, out_buffer_size, out_granted_handle,
//   out_status, out_released and out_washed. The receiver must take it then.
//   Sequence after acceptance: purge, refused and early-out operations go
//   from the check straight to the commit. An acquire that passes its checks
//   runs a restoring remainder divider, the doubling steps of the rounding
//   and the bucket lookup steps. A reclaim that reaches the wash check runs
//   the bucket count steps and the histogram scan. One operation is in
//   flight at a time; a new one may start in the cycle its result is shown.
//   Configuration writes (cfg_we, cfg_index, cfg_data) belong to idle
//   periods. Reset restores register defaults and clears the buffer state
//   and histogram.
// ---------------------------------------------------------------------------
module adaptive_buffer_size_policy
  import absp_pkg::*;
#(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_operation,
  input  logic [SIZE_W-1:0] in_request_size,
  input  logic [HND_W-1:0]  in_handle,
  input  logic [TIME_W-1:0] in_now,
  output logic              out_valid,
  output logic              out_granted,
  output logic [SIZE_W-1:0] out_buffer_size,
  output logic [HND_W-1:0]  out_granted_handle,
  output logic [2:0]        out_status,
  output logic              out_released,
  output logic              out_washed
);

  cmd_t      cmd;
  dp_flags_t flags;

  absp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .flags (flags),
    .cmd   (cmd),
    .busy  (busy)
  );

  absp_dp #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_operation       (in_operation),
    .in_request_size    (in_request_size),
    .in_handle          (in_handle),
    .in_now             (in_now),
    .cmd                (cmd),
    .flags              (flags),
    .out_valid          (out_valid),
    .out_granted        (out_granted),
    .out_buffer_size    (out_buffer_size),
    .out_granted_handle (out_granted_handle),
    .out_status         (out_status),
    .out_released       (out_released),
    .out_washed         (out_washed)
  );

endmodule

// ===== design/absp_ctrl.sv =====
// ---------------------------------------------------------------------------
// absp_ctrl
// Sequencer: steps the datapath through check, divide, doubling, bucket
// count, histogram scan and commit for one operation at a time.
// ---------------------------------------------------------------------------
module absp_ctrl
  import absp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  dp_flags_t flags,
  output cmd_t      cmd,
  output logic      busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd       = CMD_LOAD;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        case (flags.op)
          OP_ACQUIRE: state_nxt = flags.acq_stop ? S_FIN : S_DIV;
          OP_RECLAIM: state_nxt = flags.rcl_stop ? S_FIN : S_CNT;
          default:    state_nxt = S_FIN;
        endcase
      end
      S_DIV: begin
        cmd = CMD_DIV;
        if (flags.div_done) state_nxt = S_DBL;
      end
      S_DBL: begin
        cmd = CMD_DBL;
        if (flags.dbl_done) state_nxt = S_CNT;
      end
      S_CNT: begin
        cmd = CMD_CNT;
        if (flags.cnt_done) begin
          state_nxt = (flags.op == OP_RECLAIM) ? S_SCAN : S_FIN;
        end
      end
      S_SCAN: begin
        cmd = CMD_SCAN;
        if (flags.scan_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd       = CMD_FIN;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== design/absp_dp.sv =====
// ---------------------------------------------------------------------------
// absp_dp
// Datapath: configuration, buffer state, size histogram and the iterative
// units for rounding, bucket lookup and the percentile scan.
// ---------------------------------------------------------------------------
module absp_dp
  import absp_pkg::*;
#(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic [1:0]        in_operation,
  input  logic [SIZE_W-1:0] in_request_size,
  input  logic [HND_W-1:0]  in_handle,
  input  logic [TIME_W-1:0] in_now,
  input  cmd_t              cmd,
  output dp_flags_t         flags,
  output logic              out_valid,
  output logic              out_granted,
  output logic [SIZE_W-1:0] out_buffer_size,
  output logic [HND_W-1:0]  out_granted_handle,
  output logic [2:0]        out_status,
  output logic              out_released,
  output logic              out_washed
);

  localparam int KW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int CW = $clog2(NUM_BUCKETS + 1);
  localparam int TW = BASIC_W + NUM_BUCKETS;

  // configuration
  logic [BASIC_W-1:0] basic_r;
  logic [SIZE_W-1:0]  limit_r, maxreq_r;
  logic [WINT_W-1:0]  wint_r;
  logic [PCT_W-1:0]   wpct_r;

  // buffer state
  logic               holding_r, in_use_r;
  logic [SIZE_W-1:0]  held_r, total_r;
  logic [TIME_W-1:0]  atime_r;
  logic [HND_W-1:0]   aid_r;
  logic [SIZE_W-1:0]  hist_r [NUM_BUCKETS];

  // operation registers
  logic [1:0]         op_r;
  logic [SIZE_W-1:0]  req_r, dq_r, s_r, cs_r;
  logic [HND_W-1:0]   hnd_r;
  logic [TIME_W-1:0]  now_r;
  logic [BASIC_W:0]   rem_r;
  logic [5:0]         dcnt_r, i_r;
  logic [SIZE_W:0]    is_r, sum_r;
  logic [CW-1:0]      c_r, j_r;
  logic [39:0]        thr_r;
  logic               found_r;
  logic [KW-1:0]      k_r;

  logic [BASIC_W-1:0] b_eff;
  logic [BASIC_W:0]   rem_sh;
  logic [SIZE_W:0]    s_dbl, cs_dbl;
  logic [SIZE_W-1:0]  s_nxt, cs_nxt, real_sz, new_held;
  logic               keep, need_alloc, fits, rec_ok, age_ok, is_small, wash_ok;
  logic               idx_run, cnt_run, hit;
  logic [TIME_W-1:0]  age;
  logic [39:0]        sum100;
  logic [TW-1:0]      tgt;

  // committed results
  logic               holding_nxt, in_use_nxt, granted_nxt, released_nxt, washed_nxt;
  logic               alloc_nxt, rec_nxt, clr_nxt;
  logic [2:0]         status_nxt;
  logic [SIZE_W-1:0]  held_nxt;

  assign b_eff  = (basic_r == '0) ? BASIC_W'(1) : basic_r;
  assign rem_sh = {rem_r[BASIC_W-1:0], dq_r[SIZE_W-1]};

  assign s_dbl = {s_r, 1'b0};
  assign s_nxt = (s_dbl > {1'b0, limit_r}) ? limit_r : s_dbl[SIZE_W-1:0];
  assign cs_dbl = {cs_r, 1'b0};
  assign cs_nxt = (cs_dbl > {1'b0, limit_r}) ? limit_r : cs_dbl[SIZE_W-1:0];

  assign keep       = (req_r <= SIZE_W'(b_eff)) || (rem_r == '0);
  assign real_sz    = keep ? req_r : s_r;
  assign need_alloc = !holding_r || (held_r < req_r);
  assign new_held   = need_alloc ? real_sz : held_r;
  assign fits       = (new_held >= req_r);
  assign rec_ok     = (i_r < 6'(c_r)) && (total_r != '1);

  assign age      = now_r - atime_r;
  assign age_ok   = (now_r >= atime_r) && (age >= TIME_W'(wint_r));
  assign is_small = (held_r <= SIZE_W'(b_eff));
  assign tgt      = found_r ? (TW'(b_eff) << k_r) : TW'(b_eff);
  assign wash_ok  = age_ok && (tgt < TW'(held_r));

  assign idx_run = (is_r < {1'b0, real_sz});
  assign cnt_run = (cs_r < limit_r) && (c_r < CW'(NUM_BUCKETS));
  assign sum100  = 40'(sum_r) * 40'd100;
  assign hit     = (j_r != '0) && (sum100 >= thr_r);

  assign flags.op        = op_r;
  assign flags.acq_stop  = (req_r == '0) || (req_r > maxreq_r) || in_use_r;
  assign flags.rcl_stop  = !holding_r || (hnd_r != aid_r) || is_small || !age_ok ||
                           (total_r == '0);
  assign flags.div_done  = dcnt_r[5];
  assign flags.dbl_done  = keep || (s_r >= req_r) || (s_nxt == s_r);
  assign flags.cnt_done  = !idx_run && !cnt_run;
  assign flags.scan_done = hit || (j_r == c_r);

  always_comb begin
    holding_nxt  = holding_r;
    held_nxt     = held_r;
    in_use_nxt   = in_use_r;
    granted_nxt  = 1'b0;
    released_nxt = 1'b0;
    washed_nxt   = 1'b0;
    alloc_nxt    = 1'b0;
    rec_nxt      = 1'b0;
    clr_nxt      = 1'b0;
    status_nxt   = ST_OK;
    case (op_r)
      OP_ACQUIRE: begin
        if ((req_r == '0) || (req_r > maxreq_r)) begin
          status_nxt = ST_BAD_SIZE;
        end else if (in_use_r) begin
          status_nxt = ST_BUSY;
        end else begin
          alloc_nxt   = need_alloc;
          holding_nxt = 1'b1;
          held_nxt    = new_held;
          if (fits) begin
            granted_nxt = 1'b1;
            in_use_nxt  = 1'b1;
            rec_nxt     = rec_ok;
          end else begin
            status_nxt = ST_BAD_SIZE;
          end
        end
      end
      OP_RECLAIM: begin
        if (!holding_r || (hnd_r != aid_r)) begin
          status_nxt = ST_WRONG_HND;
        end else begin
          in_use_nxt = 1'b0;
          if (is_small || wash_ok) begin
            holding_nxt  = 1'b0;
            held_nxt     = '0;
            released_nxt = 1'b1;
            washed_nxt   = !is_small;
            clr_nxt      = !is_small;
          end
        end
      end
      OP_PURGE: begin
        if (holding_r) begin
          if (!in_use_r) begin
            holding_nxt  = 1'b0;
            held_nxt     = '0;
            released_nxt = 1'b1;
          end else begin
            status_nxt = ST_PURGE_USE;
          end
        end
      end
      default: status_nxt = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      basic_r   <= BASIC_W'(4096);
      limit_r   <= SIZE_W'(67108864);
      maxreq_r  <= SIZE_W'(67108864);
      wint_r    <= WINT_W'(60000000);
      wpct_r    <= PCT_W'(90);
      holding_r <= 1'b0;
      held_r    <= '0;
      in_use_r  <= 1'b0;
      atime_r   <= '0;
      aid_r     <= '0;
      total_r   <= '0;
      for (int n = 0; n < NUM_BUCKETS; n++) hist_r[n] <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_BASIC_SIZE:    basic_r  <= cfg_data[BASIC_W-1:0];
          REG_BUFFER_LIMIT:  limit_r  <= cfg_data[SIZE_W-1:0];
          REG_MAX_REQUEST:   maxreq_r <= cfg_data[SIZE_W-1:0];
          REG_WASH_INTERVAL: wint_r   <= cfg_data[WINT_W-1:0];
          REG_WASH_PERCENT:  wpct_r   <= cfg_data[PCT_W-1:0];
          default: ;
        endcase
      end
      if (cmd == CMD_FIN) begin
        out_valid <= 1'b1;
        holding_r <= holding_nxt;
        held_r    <= held_nxt;
        in_use_r  <= in_use_nxt;
        if (alloc_nxt) begin
          atime_r <= now_r;
          aid_r   <= aid_r + HND_W'(1);
        end
        if (rec_nxt) begin
          hist_r[i_r[KW-1:0]] <= hist_r[i_r[KW-1:0]] + SIZE_W'(1);
          total_r             <= total_r + SIZE_W'(1);
        end
        if (clr_nxt) begin
          for (int n = 0; n < NUM_BUCKETS; n++) hist_r[n] <= '0;
          total_r <= '0;
        end
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        op_r    <= in_operation;
        req_r   <= in_request_size;
        dq_r    <= in_request_size;
        hnd_r   <= in_handle;
        now_r   <= in_now;
        rem_r   <= '0;
        dcnt_r  <= '0;
        s_r     <= SIZE_W'(b_eff);
        is_r    <= (SIZE_W + 1)'(b_eff);
        i_r     <= '0;
        cs_r    <= SIZE_W'(b_eff);
        c_r     <= CW'(1);
        sum_r   <= '0;
        j_r     <= '0;
        found_r <= 1'b0;
        k_r     <= '0;
        thr_r   <= (40'({1'b0, wpct_r}) + 40'd1) * 40'(total_r);
      end
      CMD_DIV: begin
        // restoring division, one quotient bit per transfer of dq_r msb
        if (!dcnt_r[5]) begin
          rem_r  <= (rem_sh >= {1'b0, b_eff}) ? rem_sh - {1'b0, b_eff} : rem_sh;
          dq_r   <= {dq_r[SIZE_W-2:0], 1'b0};
          dcnt_r <= dcnt_r + 6'd1;
        end
      end
      CMD_DBL: begin
        if (!((s_r >= req_r) || (s_nxt == s_r) || keep)) s_r <= s_nxt;
      end
      CMD_CNT: begin
        if (idx_run) begin
          is_r <= {is_r[SIZE_W-1:0], 1'b0};
          i_r  <= i_r + 6'd1;
        end
        if (cnt_run) begin
          cs_r <= cs_nxt;
          c_r  <= c_r + CW'(1);
        end
      end
      CMD_SCAN: begin
        if (hit) begin
          found_r <= 1'b1;
          k_r     <= KW'(j_r - CW'(1));
        end else if (j_r != c_r) begin
          sum_r <= sum_r + (SIZE_W + 1)'(hist_r[j_r[KW-1:0]]);
          j_r   <= j_r + CW'(1);
        end
      end
      CMD_FIN: begin
        out_granted        <= granted_nxt;
        out_buffer_size    <= holding_nxt ? held_nxt : '0;
        out_granted_handle <= alloc_nxt ? aid_r + HND_W'(1) : aid_r;
        out_status         <= status_nxt;
        out_released       <= released_nxt;
        out_washed         <= washed_nxt;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/absp_chk.sv =====
// ---------------------------------------------------------------------------
// absp_chk
// Port-level checks for the adaptive buffer size policy block.
// ---------------------------------------------------------------------------
module absp_chk
  import absp_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic       out_granted,
  input logic [2:0] out_status,
  input logic       out_released,
  input logic       out_washed
);

  // a taken operation keeps the block busy next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("operation not started");

  // results come only out of a running operation
  a_res_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without operation");

  a_single_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("repeated result");

  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_granted |-> out_status == ST_OK && !out_released)
    else $error("grant with error or release");

  a_wash_rel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_washed |-> out_released) else $error("wash without release");

endmodule

bind adaptive_buffer_size_policy absp_chk u_absp_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_granted  (out_granted),
  .out_status   (out_status),
  .out_released (out_released),
  .out_washed   (out_washed)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Drives acquire, reclaim, purge and no-op transfers into the buffer policy block
// under several register settings and checks every result against a model.
// ---------------------------------------------------------------------------

class buf_scoreboard;
  typedef struct {
    logic        granted;
    logic [31:0] buffer_size;
    logic [7:0]  handle;
    logic [2:0]  status;
    logic        released;
    logic        washed;
  } outcome_t;

  outcome_t pending[$];
  int errors;

  // policy registers
  logic [20:0] basic_size;
  logic [31:0] buffer_limit;
  logic [31:0] max_request;
  logic [39:0] wash_gap;
  logic [6:0]  wash_percent;

  // buffer state
  bit          holding;
  logic [31:0] held_size;
  bit          in_use;
  logic [47:0] alloc_time;
  logic [7:0]  alloc_id;
  logic [31:0] histo[16];
  logic [31:0] total_grants;

  function new();
    basic_size = 4096;
    buffer_limit = 67108864;
    max_request = 67108864;
    wash_gap = 60000000;
    wash_percent = 90;
    holding = 0;
    held_size = 0;
    in_use = 0;
    alloc_time = 0;
    alloc_id = 0;
    foreach (histo[i]) histo[i] = 0;
    total_grants = 0;
    errors = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [39:0] val);
    case (idx)
      absp_pkg::REG_BASIC_SIZE:    basic_size = val[20:0];
      absp_pkg::REG_BUFFER_LIMIT:  buffer_limit = val[31:0];
      absp_pkg::REG_MAX_REQUEST:   max_request = val[31:0];
      absp_pkg::REG_WASH_INTERVAL: wash_gap = val;
      absp_pkg::REG_WASH_PERCENT:  wash_percent = val[6:0];
      default: ;
    endcase
  endfunction

  function longint unsigned unit_size();
    return (basic_size == 0) ? 64'd1 : 64'(basic_size);
  endfunction

  function longint unsigned rounded(longint unsigned sz);
    longint unsigned s, n;
    if (sz <= unit_size() || sz % unit_size() == 0) return sz;
    s = unit_size();
    while (s < sz) begin
      n = s << 1;
      if (n > buffer_limit) n = buffer_limit;
      if (n == s) break;
      s = n;
    end
    return s;
  endfunction

  function int unsigned num_buckets();
    longint unsigned s;
    int unsigned c;
    s = unit_size();
    c = 1;
    while (s < buffer_limit && c < 16) begin
      s = s << 1;
      if (s > buffer_limit) s = buffer_limit;
      c++;
    end
    return c;
  endfunction

  function int unsigned bucket_of(longint unsigned r);
    longint unsigned s;
    int unsigned i;
    s = unit_size();
    i = 0;
    while (s < r && i < 64) begin
      s = s << 1;
      i++;
    end
    return i;
  endfunction

  function longint unsigned percentile_size();
    longint unsigned sum;
    int unsigned c;
    sum = 0;
    if (total_grants == 0) return unit_size();
    c = num_buckets();
    for (int unsigned i = 0; i < c; i++) begin
      sum += histo[i];
      if (sum * 100 / total_grants > wash_percent) return unit_size() << i;
    end
    return unit_size();
  endfunction

  function void note_transfer(logic [1:0] op, logic [31:0] req, logic [7:0] hnd,
                              logic [47:0] now);
    outcome_t o;
    longint unsigned real_sz;
    int unsigned idx;
    o = '{default: 0};
    case (op)
      absp_pkg::OP_ACQUIRE: begin
        if (req == 0 || req > max_request) o.status = absp_pkg::ST_BAD_SIZE;
        else if (in_use) o.status = absp_pkg::ST_BUSY;
        else begin
          real_sz = rounded(req);
          if (!holding || held_size < req) begin
            holding = 1;
            held_size = real_sz[31:0];
            alloc_time = now;
            alloc_id = alloc_id + 8'd1;
          end
          if (held_size >= req) begin
            idx = bucket_of(real_sz);
            o.granted = 1;
            in_use = 1;
            if (idx < num_buckets() && total_grants != 32'hFFFF_FFFF) begin
              histo[idx] = histo[idx] + 32'd1;
              total_grants = total_grants + 32'd1;
            end
          end else o.status = absp_pkg::ST_BAD_SIZE;
        end
      end
      absp_pkg::OP_RECLAIM: begin
        if (!holding || hnd != alloc_id) o.status = absp_pkg::ST_WRONG_HND;
        else begin
          in_use = 0;
          if (held_size <= unit_size()) begin
            holding = 0;
            held_size = 0;
            o.released = 1;
          end else if (now >= alloc_time && now - alloc_time >= wash_gap &&
                       percentile_size() < held_size) begin
            holding = 0;
            held_size = 0;
            foreach (histo[i]) histo[i] = 0;
            total_grants = 0;
            o.released = 1;
            o.washed = 1;
          end
        end
      end
      absp_pkg::OP_PURGE: begin
        if (holding) begin
          if (!in_use) begin
            holding = 0;
            held_size = 0;
            o.released = 1;
          end else o.status = absp_pkg::ST_PURGE_USE;
        end
      end
      default: ;
    endcase
    o.buffer_size = holding ? held_size : 32'd0;
    o.handle = alloc_id;
    pending = {pending, o};
  endfunction

  function void check_result(outcome_t got);
    outcome_t exp;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result", $time);
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (got.granted !== exp.granted) begin
      $display("%0t: granted exp %0d got %0d", $time, exp.granted, got.granted);
      errors++;
    end
    if (got.buffer_size !== exp.buffer_size) begin
      $display("%0t: buffer_size exp %0d got %0d", $time, exp.buffer_size,
               got.buffer_size);
      errors++;
    end
    if (got.handle !== exp.handle) begin
      $display("%0t: handle exp %0d got %0d", $time, exp.handle, got.handle);
      errors++;
    end
    if (got.status !== exp.status) begin
      $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
      errors++;
    end
    if (got.released !== exp.released) begin
      $display("%0t: released exp %0d got %0d", $time, exp.released, got.released);
      errors++;
    end
    if (got.washed !== exp.washed) begin
      $display("%0t: washed exp %0d got %0d", $time, exp.washed, got.washed);
      errors++;
    end
  endfunction
endclass

module tb;
  import absp_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              start;
  logic              busy;
  logic [1:0]        in_operation;
  logic [SIZE_W-1:0] in_request_size;
  logic [HND_W-1:0]  in_handle;
  logic [TIME_W-1:0] in_now;
  logic              out_valid;
  logic              out_granted;
  logic [SIZE_W-1:0] out_buffer_size;
  logic [HND_W-1:0]  out_granted_handle;
  logic [2:0]        out_status;
  logic              out_released;
  logic              out_washed;

  buf_scoreboard sb;
  logic [47:0]   clock_now;

  adaptive_buffer_size_policy i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy),
    .in_operation(in_operation), .in_request_size(in_request_size),
    .in_handle(in_handle), .in_now(in_now),
    .out_valid(out_valid), .out_granted(out_granted),
    .out_buffer_size(out_buffer_size), .out_granted_handle(out_granted_handle),
    .out_status(out_status), .out_released(out_released), .out_washed(out_washed)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result('{out_granted, out_buffer_size, out_granted_handle,
                        out_status, out_released, out_washed});
    end
  end

  task automatic wait_quiet();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [39:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  // one command transfer; start is held until accepted and dropped by the
  // next idle gap or by wait_quiet
  task automatic issue(logic [1:0] op, logic [31:0] req, logic [7:0] hnd,
                       logic [47:0] now);
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_request_size <= req;
    in_handle <= hnd;
    in_now <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_transfer(op, req, hnd, now);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_size();
    case ($urandom_range(0, 5))
      0: return $urandom_range(1, 8);
      1: return 32'($urandom_range(1, 4) * sb.unit_size());
      2: return $urandom_range(1, 32'(3 * sb.unit_size()));
      3: return $urandom;
      4: return $urandom_range(1, sb.max_request);
      default: return $urandom_range(1, 70000);
    endcase
  endfunction

  function automatic logic [47:0] next_time();
    case ($urandom_range(0, 7))
      0: clock_now = 48'({$urandom, $urandom});
      1: clock_now = clock_now - $urandom_range(0, 1000);
      2: clock_now = clock_now + sb.wash_gap;
      default: clock_now = clock_now + $urandom_range(0, 100000);
    endcase
    return clock_now;
  endfunction

  task automatic random_items(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        issue(OP_ACQUIRE, rand_size(), 8'($urandom), next_time());
      end else if (r < 8) begin
        issue(OP_RECLAIM, $urandom, (r == 7) ? 8'($urandom) : sb.alloc_id, next_time());
      end else begin
        issue((r == 8) ? OP_PURGE : OP_NONE, $urandom, 8'($urandom), next_time());
      end
    end
  endtask

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    sb = new();
    clock_now = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    start = 1'b0;
    in_operation = OP_ACQUIRE;
    in_request_size = '0;
    in_handle = '0;
    in_now = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: edges of fields and every special case
    issue(OP_RECLAIM, 0, 8'hFF, 0);
    issue(OP_ACQUIRE, 0, 0, 0);
    issue(OP_ACQUIRE, 32'hFFFF_FFFF, 0, 0);
    issue(OP_ACQUIRE, 5000, 0, 100);
    issue(OP_ACQUIRE, 100, 0, 100);
    issue(OP_PURGE, 0, 0, 100);
    issue(OP_RECLAIM, 0, 8'h00, 100);
    issue(OP_RECLAIM, 0, sb.alloc_id, 50);
    issue(OP_ACQUIRE, 8192, 0, 48'hFFFF_FFFF_FFFF);
    issue(OP_RECLAIM, 0, sb.alloc_id, 48'hFFFF_FFFF_FFFF);
    issue(OP_PURGE, 0, 0, 0);
    issue(OP_PURGE, 0, 0, 0);
    issue(OP_NONE, 32'hFFFF_FFFF, 8'hFF, 48'hFFFF_FFFF_FFFF);
    issue(OP_ACQUIRE, 1, 0, 0);
    issue(OP_RECLAIM, 0, sb.alloc_id, 0);
    wait_quiet();
    write_cfg(REG_WASH_INTERVAL, 0);
    write_cfg(REG_WASH_PERCENT, 0);
    issue(OP_ACQUIRE, 67108864, 0, 10);
    issue(OP_RECLAIM, 0, sb.alloc_id, 10);
    wait_quiet();
    write_cfg(REG_BUFFER_LIMIT, 10000);
    write_cfg(REG_MAX_REQUEST, 32'hFFFF_FFFF);
    issue(OP_ACQUIRE, 9000, 0, 0);
    issue(OP_ACQUIRE, 20000, 0, 0);
    issue(OP_PURGE, 0, 0, 0);
    wait_quiet();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_cfg(REG_BASIC_SIZE, 0);
          write_cfg(REG_BUFFER_LIMIT, 32'hFFFF_FFFF);
          write_cfg(REG_WASH_PERCENT, 100);
        end
        1: begin
          write_cfg(REG_BASIC_SIZE, 1048576);
          write_cfg(REG_BUFFER_LIMIT, 1);
          write_cfg(REG_MAX_REQUEST, 1);
        end
        2: begin
          write_cfg(REG_BASIC_SIZE, 21'h1F_FFFF);
          write_cfg(REG_BUFFER_LIMIT, 32'hFFFF_FFFF);
          write_cfg(REG_MAX_REQUEST, 32'hFFFF_FFFF);
          write_cfg(REG_WASH_INTERVAL, 40'hFF_FFFF_FFFF);
          write_cfg(REG_WASH_PERCENT, 7'h7F);
        end
        3: begin
          write_cfg(REG_BASIC_SIZE, 4096);
          write_cfg(REG_BUFFER_LIMIT, 67108864);
          write_cfg(REG_MAX_REQUEST, 67108864);
          write_cfg(REG_WASH_INTERVAL, 50000);
          write_cfg(REG_WASH_PERCENT, 50);
        end
        4: begin
          write_cfg(REG_BASIC_SIZE, $urandom_range(1, 1024));
          write_cfg(REG_BUFFER_LIMIT, $urandom_range(1, 1 << 20));
          write_cfg(REG_WASH_INTERVAL, $urandom_range(0, 3000));
          write_cfg(REG_WASH_PERCENT, $urandom_range(0, 100));
        end
        default: begin
          write_cfg(REG_BASIC_SIZE, 16);
          write_cfg(REG_BUFFER_LIMIT, 32'hFFFF_FFFF);
          write_cfg(REG_MAX_REQUEST, 32'hFFFF_FFFF);
          write_cfg(REG_WASH_INTERVAL, 0);
          write_cfg(REG_WASH_PERCENT, 30);
        end
      endcase
      random_items(72);
      wait_quiet();
    end

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== adaptive_buffer_size_policy.f =====
design/absp_pkg.sv
design/absp_ctrl.sv
design/absp_dp.sv
design/adaptive_buffer_size_policy.sv
design/absp_chk.sv
tb/tb.sv
